// ===== hdl/rkint_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkint_pkg: shared types and constants for the RK4 stage integrator
// Operation codes, slope store geometry, fixed-point and divider constants.
// ----------------------------------------------------------------------------
package rkint_pkg;

  localparam int NUM_VARS  = 64;
  localparam int VAR_AW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int FRAC_BITS = 16;

  typedef enum logic [2:0] {
    FN_COPY     = 3'd0,
    FN_STAGE1   = 3'd1,
    FN_STAGE2   = 3'd2,
    FN_STAGE3   = 3'd3,
    FN_COMBINE  = 3'd4,
    FN_PROGRESS = 3'd5,
    FN_ZERO     = 3'd6
  } func_t;

  // floor(w/3) = (w * ceil(2^37/3)) >> 37, exact for w below 2^37
  localparam int DIV3_SHIFT  = 37;
  localparam int RECIP_SPLIT = 18;
  localparam logic [63:0] DIV3_RECIP = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [RECIP_SPLIT-1:0] RECIP_HI = RECIP_SPLIT'(DIV3_RECIP >> RECIP_SPLIT);
  localparam logic [RECIP_SPLIT-1:0] RECIP_LO = RECIP_SPLIT'(DIV3_RECIP);

  // (s + 3) lifted by 6*2^32 so the combine sum is never negative
  localparam logic signed [36:0] COMB_BIAS   = (37'sd6 <<< 32) + 37'sd3;
  localparam logic signed [48:0] COMB_OFFSET = 49'sd1 <<< 32;

  typedef struct packed {
    logic              rd_en;
    logic              wr;
    logic              clr;
    logic              in_range;
    logic [VAR_AW-1:0] addr;
    logic [31:0]       wdata;
  } slope_req_t;

endpackage
`default_nettype wire

// ===== hdl/rkint_slope_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkint_slope_store: one per-variable slope memory
// Single-port array with registered read; per-entry valid bits make
// unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module rkint_slope_store
  import rkint_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  slope_req_t         req,
  output logic signed [31:0] rdata
);

  logic [31:0]         mem [NUM_VARS];
  logic [NUM_VARS-1:0] vld;
  logic [31:0]         rd_word;
  logic                rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (req.in_range && req.wr) begin
        vld[req.addr] <= 1'b1;
      end else if (req.in_range && req.clr) begin
        vld[req.addr] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_hit <= req.in_range && vld[req.addr];
      end
    end
  end

  assign rdata = rd_hit ? $signed(rd_word) : 32'sd0;

endmodule
`default_nettype wire

// ===== hdl/rkint_arith.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkint_arith: five-stage arithmetic pipeline
// Input register, h*v product and combine sum, rounding and divide-by-3
// partial products, final add, saturation into the result register.
// ----------------------------------------------------------------------------
module rkint_arith
  import rkint_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] position,
  input  logic signed [31:0] rate,
  input  logic signed [31:0] slope_one,
  input  logic signed [31:0] slope_two,
  input  logic signed [31:0] slope_three,
  input  logic [30:0]        step_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               overflow
);

  logic v1, v2, v3, v4;
  logic free1, free2, free3, free4, free5;

  func_t              s1_func, s2_func, s3_func;
  logic signed [31:0] s1_x, s1_v, s2_x, s3_x;
  logic signed [63:0] s2_prod;
  logic [34:0]        s2_w;
  logic signed [47:0] s3_rnd;
  logic [52:0]        s3_ph, s3_pl;
  logic signed [48:0] s4_r;

  logic signed [63:0] prod_c;
  logic signed [36:0] sum_c;
  logic               half17_c;
  logic signed [63:0] rnd_sum_c;
  logic signed [47:0] rnd_c;
  logic [71:0]        comb_prod_c;
  logic [34:0]        quot_c;
  logic signed [48:0] r_c;
  logic               ovf_c;
  logic signed [31:0] sat_c;

  assign free5    = !out_valid || out_ready;
  assign free4    = !v4 || free5;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (free5) out_valid <= v4;
    end
  end

  // stage 2: product and combine sum
  assign prod_c = 64'(signed'({1'b0, step_size})) * 64'(s1_v);
  assign sum_c  = 37'(slope_one) + (37'(slope_two) <<< 1) + (37'(slope_three) <<< 1)
                + 37'(s1_v) + COMB_BIAS;

  // stage 3: round h*v back to Q16.16, split reciprocal multiply
  assign half17_c  = (s2_func == FN_STAGE1) || (s2_func == FN_STAGE2);
  assign rnd_sum_c = s2_prod + (half17_c ? (64'sd1 <<< FRAC_BITS)
                                         : (64'sd1 <<< (FRAC_BITS - 1)));
  assign rnd_c     = half17_c ? 48'(rnd_sum_c >>> (FRAC_BITS + 1))
                              : 48'(rnd_sum_c >>> FRAC_BITS);

  // stage 4: final add
  assign comb_prod_c = (72'(s3_ph) << RECIP_SPLIT) + 72'(s3_pl);
  assign quot_c      = 35'(comb_prod_c >> DIV3_SHIFT);

  always_comb begin
    case (s3_func)
      FN_COPY:     r_c = 49'(s3_x);
      FN_STAGE1,
      FN_STAGE2,
      FN_STAGE3,
      FN_PROGRESS: r_c = 49'(s3_x) + 49'(s3_rnd);
      FN_COMBINE:  r_c = $signed(49'(quot_c)) - COMB_OFFSET;
      default:     r_c = '0;
    endcase
  end

  // stage 5: saturate
  assign ovf_c = !((&s4_r[48:31]) || (~|s4_r[48:31]));
  assign sat_c = !ovf_c ? s4_r[31:0] : (s4_r[48] ? 32'sh80000000 : 32'sh7FFFFFFF);

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_func <= func_t'(func);
      s1_x    <= position;
      s1_v    <= rate;
    end
    if (free2) begin
      s2_func <= s1_func;
      s2_x    <= s1_x;
      s2_prod <= prod_c;
      s2_w    <= sum_c[35:1];
    end
    if (free3) begin
      s3_func <= s2_func;
      s3_x    <= s2_x;
      s3_rnd  <= rnd_c;
      s3_ph   <= 53'(s2_w) * 53'(RECIP_HI);
      s3_pl   <= 53'(s2_w) * 53'(RECIP_LO);
    end
    if (free4) begin
      s4_r <= r_c;
    end
    if (free5) begin
      value    <= sat_c;
      overflow <= ovf_c;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rk4_stage_integrator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_stage_integrator: staged RK4 update, one variable per word
// Q16.16 fixed point; slope stores k1..k3 per variable; saturating results.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   config   | cfg_write              | cfg_data (step size h)
//   input    | in_valid / in_ready    | func, var_index, position, rate
//   output   | out_valid / out_ready  | value, overflow
//
// One word accepted per cycle while the output is not stalled; each result
// passes the input, product, rounding, add and saturation registers.
// Slope reads and writes take place at the accepting edge, so words see
// the store in order with no forwarding.
// Reset clears the step size and all slope valid bits at once.
// A stalled output holds the pipeline stage by stage; bubbles close up.
// ----------------------------------------------------------------------------
module rk4_stage_integrator
  import rkint_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [5:0]         var_index,
  input  logic signed [31:0] position,
  input  logic signed [31:0] rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               overflow
);

  logic [30:0]        step_size;
  logic               accept;
  logic               in_range;
  func_t              op;
  slope_req_t         req_one, req_two, req_three;
  logic signed [31:0] k_one, k_two, k_three;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= '0;
    end else if (cfg_write) begin
      step_size <= cfg_data;
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_range = 32'(var_index) < NUM_VARS;
  assign op       = func_t'(func);

  always_comb begin
    req_one.rd_en    = in_ready;
    req_one.wr       = accept && in_range && (op == FN_STAGE1);
    req_one.clr      = accept && (op == FN_ZERO);
    req_one.in_range = in_range;
    req_one.addr     = VAR_AW'(var_index);
    req_one.wdata    = rate;

    req_two          = req_one;
    req_two.wr       = accept && in_range && (op == FN_STAGE2);

    req_three        = req_one;
    req_three.wr     = accept && in_range && (op == FN_STAGE3);
  end

  rkint_slope_store u_slope_one (
    .clk   (clk),
    .rst   (rst),
    .req   (req_one),
    .rdata (k_one)
  );

  rkint_slope_store u_slope_two (
    .clk   (clk),
    .rst   (rst),
    .req   (req_two),
    .rdata (k_two)
  );

  rkint_slope_store u_slope_three (
    .clk   (clk),
    .rst   (rst),
    .req   (req_three),
    .rdata (k_three)
  );

  rkint_arith u_arith (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .position    (position),
    .rate        (rate),
    .slope_one   (k_one),
    .slope_two   (k_two),
    .slope_three (k_three),
    .step_size   (step_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire

// ===== test/rk4_stage_integrator_checker.sv =====
// ----------------------------------------------------------------------------
// rk4_stage_integrator_checker: result predictor and scoreboard
// Watches the step size port and both word channels. Each accepted input
// word is run through a local model of the slope stores and the Q16.16
// arithmetic, and the expected result is queued. Each accepted output word
// is compared field by field with the oldest entry in the queue.
// ----------------------------------------------------------------------------
module rk4_stage_integrator_checker
  import rkint_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         func,
  input  logic [5:0]         var_index,
  input  logic signed [31:0] position,
  input  logic signed [31:0] rate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] value,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic               overflow;
  } rk_result_t;

  rk_result_t         result_q[$];
  logic [30:0]        step_h;
  logic signed [31:0] slope1_mem[NUM_VARS];
  logic signed [31:0] slope2_mem[NUM_VARS];
  logic signed [31:0] slope3_mem[NUM_VARS];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // round to nearest, ties toward plus infinity
  function automatic longint round_scale(longint p, int unsigned s);
    return (p + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic rk_result_t clamp_q(longint r);
    rk_result_t res;
    if (r > Q_MAX) begin
      res.value    = 32'sh7fffffff;
      res.overflow = 1'b1;
    end else if (r < Q_MIN) begin
      res.value    = 32'sh80000000;
      res.overflow = 1'b1;
    end else begin
      res.value    = 32'(r);
      res.overflow = 1'b0;
    end
    return res;
  endfunction

  task automatic predict_word(input logic [2:0] f, input logic [5:0] idx,
                              input logic signed [31:0] x, input logic signed [31:0] v);
    longint xl, vl, hl, k1, k2, k3, sum, num, quo, r;
    logic   in_range;
    in_range = (int'(idx) < NUM_VARS);
    xl = x;
    vl = v;
    hl = longint'(step_h);
    k1 = 0;
    k2 = 0;
    k3 = 0;
    if (in_range) begin
      k1 = slope1_mem[idx];
      k2 = slope2_mem[idx];
      k3 = slope3_mem[idx];
    end
    case (f)
      FN_COPY: r = xl;
      FN_STAGE1, FN_STAGE2: begin
        if (in_range && f == FN_STAGE1) slope1_mem[idx] = v;
        if (in_range && f == FN_STAGE2) slope2_mem[idx] = v;
        r = xl + round_scale(hl * vl, FRAC_BITS + 1);
      end
      FN_STAGE3: begin
        if (in_range) slope3_mem[idx] = v;
        r = xl + round_scale(hl * vl, FRAC_BITS);
      end
      FN_COMBINE: begin
        sum = k1 + 2 * k2 + 2 * k3 + vl;
        num = 2 * sum + 6;
        quo = num / 12;
        if (num % 12 < 0) quo = quo - 1;
        r = quo;
      end
      FN_PROGRESS: r = xl + round_scale(hl * vl, FRAC_BITS);
      FN_ZERO: begin
        if (in_range) begin
          slope1_mem[idx] = '0;
          slope2_mem[idx] = '0;
          slope3_mem[idx] = '0;
        end
        r = 0;
      end
      default: r = 0;
    endcase
    result_q.push_back(clamp_q(r));
  endtask

  always @(posedge clk) begin
    rk_result_t want;
    if (rst) begin
      result_q.delete();
      step_h = '0;
      for (int i = 0; i < NUM_VARS; i++) begin
        slope1_mem[i] = '0;
        slope2_mem[i] = '0;
        slope3_mem[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result word: value %0d, overflow %0b", value, overflow);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            fail_count++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow);
            fail_count++;
          end
        end
      end
      if (cfg_write) step_h = cfg_data;
      if (in_valid && in_ready) predict_word(func, var_index, position, rate);
    end
    pending = result_q.size();
  end

endmodule

// ===== test/rk4_stage_integrator_tb.sv =====
// ----------------------------------------------------------------------------
// rk4_stage_integrator_tb: stimulus and verdict for the RK4 stage integrator
// Directed words hit saturation, rounding ties and slope clearing, then
// random RK4 stage sequences and stray words run under several step sizes
// and two patterns of sender and receiver stalls or none. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module rk4_stage_integrator_tb;
  import rkint_pkg::*;

  localparam int                 PERIOD       = 12;
  localparam int                 RESET_CYCLES = 11;
  localparam int                 DRAIN_CYCLES = 8;
  localparam int                 BLOCK_WORDS  = 85;
  localparam logic [2:0]         FN_UNUSED    = 3'd7;
  localparam logic signed [31:0] Q_MAX        = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN        = 32'sh80000000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [30:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic [5:0]         var_index;
  logic signed [31:0] position;
  logic signed [31:0] rate;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] value;
  logic               overflow;
  int                 fail_count;
  int                 pending;
  int                 send_idle;
  int                 recv_idle;

  rk4_stage_integrator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .var_index (var_index),
    .position  (position),
    .rate      (rate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .overflow  (overflow)
  );

  rk4_stage_integrator_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .var_index  (var_index),
    .position   (position),
    .rate       (rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .overflow   (overflow),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [2:0] f, input logic [5:0] idx,
                           input logic signed [31:0] x, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    var_index <= idx;
    position  <= x;
    rate      <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [30:0] h);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                 sent;
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic [30:0]        step_plan[6];
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    func      = FN_COPY;
    var_index = '0;
    position  = '0;
    rate      = '0;
    out_ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    step_plan[0] = 31'h00010000;
    step_plan[1] = 31'h7fffffff;
    step_plan[2] = 31'($urandom);
    step_plan[3] = 31'd0;
    step_plan[4] = 31'h00001999;
    step_plan[5] = 31'($urandom_range(0, 32'h0003ffff));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step size still at its reset value
    send_word(FN_COPY, 6'd0, Q_MAX, Q_MIN);
    send_word(FN_COPY, 6'd63, Q_MIN, Q_MAX);
    send_word(FN_STAGE1, 6'd1, Q_MAX, Q_MAX);
    send_word(FN_UNUSED, 6'd63, Q_MAX, Q_MIN);

    write_step(31'h7fffffff);
    send_word(FN_STAGE1, 6'd2, Q_MAX, Q_MAX);
    send_word(FN_STAGE2, 6'd2, Q_MIN, Q_MIN);
    send_word(FN_STAGE3, 6'd2, '0, Q_MAX);
    send_word(FN_PROGRESS, 6'd2, Q_MIN, Q_MIN);
    send_word(FN_COMBINE, 6'd2, '0, Q_MAX);
    send_word(FN_STAGE1, 6'd63, '0, Q_MIN);
    send_word(FN_STAGE2, 6'd63, '0, Q_MIN);
    send_word(FN_STAGE3, 6'd63, '0, Q_MIN);
    send_word(FN_COMBINE, 6'd63, '0, Q_MIN);
    send_word(FN_ZERO, 6'd2, Q_MAX, Q_MAX);
    send_word(FN_COMBINE, 6'd2, '0, '0);

    // rounding ties
    write_step(31'd1);
    send_word(FN_PROGRESS, 6'd3, '0, 32'sd32768);
    send_word(FN_PROGRESS, 6'd3, '0, -32'sd32768);
    send_word(FN_STAGE1, 6'd3, '0, 32'sd65536);
    send_word(FN_STAGE2, 6'd3, '0, -32'sd65536);
    send_word(FN_ZERO, 6'd5, '0, '0);
    send_word(FN_COMBINE, 6'd5, '0, 32'sd3);
    send_word(FN_COMBINE, 6'd5, '0, -32'sd3);

    for (int blk = 0; blk < 6; blk++) begin
      case (blk / 2)
        0: begin
          send_idle = 37;
          recv_idle = 88;
        end
        1: begin
          send_idle = 88;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_step(step_plan[blk]);
      sent = 0;
      while (sent < BLOCK_WORDS) begin
        if ($urandom_range(3) != 0) begin
          idx = 6'($urandom);
          x   = pick_q();
          if ($urandom_range(7) == 0) begin
            send_word(FN_ZERO, idx, pick_q(), pick_q());
            sent++;
          end
          send_word(FN_COPY, idx, x, pick_q());
          send_word(FN_STAGE1, idx, x, pick_q());
          send_word(FN_STAGE2, idx, x, pick_q());
          send_word(FN_STAGE3, idx, x, pick_q());
          send_word(FN_COMBINE, idx, x, pick_q());
          send_word(FN_PROGRESS, idx, x, pick_q());
          sent += 6;
        end else begin
          send_word(3'($urandom_range(7)), 6'($urandom), pick_q(), pick_q());
          sent++;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
